FILE: hdl/ais_pkg.sv
package ais_pkg;

  typedef enum logic [2:0] {
    LVL_PAD          = 3'd0,
    LVL_VALVES       = 3'd1,
    LVL_IGNITION     = 3'd2,
    LVL_DISCONNECTED = 3'd3,
    LVL_LAUNCH       = 3'd4
  } level_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_INV    = 2'd1,
    ST_DENIED = 2'd2,
    ST_DNE    = 2'd3
  } status_t;

  localparam logic [7:0] ACT_LAST_VALVE = 8'd11;
  localparam logic [7:0] ACT_IGNITER    = 8'd12;
  localparam logic [7:0] ACT_DUMP       = 8'd13;
  localparam logic [7:0] ACT_QD         = 8'd14;

  localparam int SHOWN_BITS = 15;
  localparam int FIRE_W     = 4;

  function automatic logic level_ok(input logic [2:0] cur, input logic [2:0] want);
    logic [3:0] cur_inc;
    logic       up;
    logic       down_valves;
    logic       down_firing;
    cur_inc     = {1'b0, cur} + 4'd1;
    up          = ({1'b0, want} == cur_inc) && (want <= LVL_LAUNCH);
    down_valves = (cur == LVL_VALVES) && (want == LVL_PAD);
    down_firing = (want == LVL_VALVES) && (cur >= LVL_IGNITION) && (cur <= LVL_LAUNCH);
    return up || down_valves || down_firing;
  endfunction

endpackage

FILE: hdl/arming_interlock_sequencer.sv
// A word accepted at the input is held in the input register, then in the result register, which
// drives the result port. One word per cycle while the result word is not stalled; the decision is a
// single pass of logic between the input and result registers, which also updates the level and actuator state.
// Reset (rst_n low, synchronous): level returns to pad, all actuators off, fire valve
// index 0, both pipeline stages empty.
module arming_interlock_sequencer #(
  parameter int ACTUATOR_COUNT = 15
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ais_pkg::FIRE_W-1:0]      cfg_fire_valve_id,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [2:0]                      in_requested_level,
  input  logic [7:0]                      in_actuator_id,
  input  logic [7:0]                      in_requested_state,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic [2:0]                      out_arm_level_now,
  output logic [ais_pkg::SHOWN_BITS-1:0]  out_actuator_bits,
  output logic                            out_update_signalled
);

  localparam int IDX_W = $clog2(ACTUATOR_COUNT);

  logic [ais_pkg::FIRE_W-1:0]    fire_id_r;
  ais_pkg::level_t               lvl_r, lvl_nxt;
  logic [ACTUATOR_COUNT-1:0]     act_r, act_nxt;

  logic                          s1_valid_r;
  logic                          s1_mode_r;
  logic [2:0]                    s1_level_r;
  logic [7:0]                    s1_id_r;
  logic [7:0]                    s1_state_r;

  logic                          out_valid_r;
  ais_pkg::status_t              status_r, status_nxt;
  logic [2:0]                    out_lvl_r;
  logic [ais_pkg::SHOWN_BITS-1:0] out_bits_r;

  logic                          out_free;
  logic                          advance;
  logic                          accept;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    logic       valve;
    logic       permit;
    logic       on;
    logic [2:0] try_lvl;
    logic       try_en;
    lvl_nxt    = lvl_r;
    act_nxt    = act_r;
    status_nxt = ais_pkg::ST_OK;
    on         = (s1_state_r != 8'd0);
    valve      = (s1_id_r <= ais_pkg::ACT_LAST_VALVE) &&
                 (s1_id_r != {{(8 - ais_pkg::FIRE_W){1'b0}}, fire_id_r});
    permit     = 1'b0;
    try_lvl    = ais_pkg::LVL_PAD;
    try_en     = 1'b0;
    unique case (lvl_r)
      ais_pkg::LVL_VALVES:       permit = valve;
      ais_pkg::LVL_IGNITION:     permit = valve || (s1_id_r == ais_pkg::ACT_QD);
      ais_pkg::LVL_DISCONNECTED: permit = valve || (s1_id_r == ais_pkg::ACT_QD) ||
                                          (s1_id_r == ais_pkg::ACT_IGNITER);
      ais_pkg::LVL_LAUNCH:       permit = 1'b1;
      default:                   permit = 1'b0;
    endcase
    if (!s1_mode_r) begin
      priority if (s1_level_r > ais_pkg::LVL_LAUNCH) begin
        status_nxt = ais_pkg::ST_INV;
      end else if (ais_pkg::level_ok(lvl_r, s1_level_r)) begin
        lvl_nxt = ais_pkg::level_t'(s1_level_r);
      end else begin
        status_nxt = ais_pkg::ST_DENIED;
      end
    end else begin
      priority if (s1_id_r == ais_pkg::ACT_DUMP) begin
        act_nxt[ais_pkg::ACT_DUMP[IDX_W-1:0]] = on;
      end else if (s1_id_r >= 8'(ACTUATOR_COUNT)) begin
        status_nxt = ais_pkg::ST_DNE;
      end else if (s1_state_r > 8'd1) begin
        status_nxt = ais_pkg::ST_INV;
      end else if (!permit) begin
        status_nxt = ais_pkg::ST_DENIED;
      end else begin
        act_nxt[s1_id_r[IDX_W-1:0]] = on;
        if (s1_id_r == ais_pkg::ACT_QD) begin
          try_en  = !on || (lvl_r < ais_pkg::LVL_DISCONNECTED);
          try_lvl = on ? ais_pkg::LVL_DISCONNECTED : ais_pkg::LVL_IGNITION;
        end else if (s1_id_r == ais_pkg::ACT_IGNITER) begin
          try_en  = !on || (lvl_r < ais_pkg::LVL_LAUNCH);
          try_lvl = on ? ais_pkg::LVL_LAUNCH : ais_pkg::LVL_DISCONNECTED;
        end
        if (try_en && ais_pkg::level_ok(lvl_r, try_lvl)) begin
          lvl_nxt = ais_pkg::level_t'(try_lvl);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fire_id_r   <= '0;
      lvl_r       <= ais_pkg::LVL_PAD;
      act_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fire_id_r <= cfg_fire_valve_id;
      end
      if (advance) begin
        lvl_r <= lvl_nxt;
        act_r <= act_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r  <= in_mode;
      s1_level_r <= in_requested_level;
      s1_id_r    <= in_actuator_id;
      s1_state_r <= in_requested_state;
    end
    if (advance) begin
      status_r   <= status_nxt;
      out_lvl_r  <= lvl_nxt;
      out_bits_r <= act_nxt[ais_pkg::SHOWN_BITS-1:0];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_arm_level_now    = out_lvl_r;
  assign out_actuator_bits    = out_bits_r;
  assign out_update_signalled = (status_r == ais_pkg::ST_OK);

endmodule

FILE: hdl/ais_checker.sv
module ais_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [1:0]                      out_status,
  input logic [2:0]                      out_arm_level_now,
  input logic [ais_pkg::SHOWN_BITS-1:0]  out_actuator_bits,
  input logic                            out_update_signalled
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_arm_level_now) && $stable(out_actuator_bits))
    else $error("stalled result word changed or vanished");

  a_update_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_update_signalled == (out_status == ais_pkg::ST_OK)))
    else $error("update flag disagrees with status");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_arm_level_now <= ais_pkg::LVL_LAUNCH))
    else $error("arming level out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present straight after reset");

endmodule

bind arming_interlock_sequencer ais_checker u_ais_checker (.*);
